### src/ppsb_pkg.sv
// Package for the ping-pong sample buffer: sizes, operation codes, controller states
// and the command struct passed from the controller to the datapath.
// No dependencies.
package ppsb_pkg;

  localparam int BYTES_PER_SAMPLE  = 14;
  localparam int SAMPLES_PER_TABLE = 256;
  localparam int TABLE_BYTES       = BYTES_PER_SAMPLE * SAMPLES_PER_TABLE;
  localparam int MEM_DEPTH         = 2 * TABLE_BYTES;

  localparam int BPOS_W = (BYTES_PER_SAMPLE > 1) ? $clog2(BYTES_PER_SAMPLE) : 1;
  localparam int SCNT_W = $clog2(SAMPLES_PER_TABLE);
  localparam int OFF_W  = $clog2(TABLE_BYTES);
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // Fixed field widths of the stream payloads.
  localparam int DATA_W  = 8;
  localparam int RADDR_W = 12;

  typedef enum logic [1:0] {
    OP_STORE   = 2'd0,
    OP_READ    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } ppsb_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ppsb_state_e;

  typedef struct packed {
    logic exec;       // execute a store, release or no-op this cycle
    logic rd_en;      // launch a table read
    logic load_now;   // load the output register from the executed operation
    logic load_read;  // load the output register from the read data
  } ppsb_cmd_t;

endpackage

### src/ppsb_ctrl.sv
// Controller of the ping-pong sample buffer: input/output handshake and
// read sequencing. Depends on ppsb_pkg.
module ppsb_ctrl
  import ppsb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ppsb_op_e  in_op_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ppsb_cmd_t cmd_o
);

  ppsb_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          if (in_op_i == OP_READ) begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_READ;
          end else begin
            cmd_o.exec     = 1'b1;
            cmd_o.load_now = 1'b1;
            out_valid_d    = 1'b1;
          end
        end
      end
      S_READ: begin
        // The read data is held until the output register can take it.
        if (out_free) begin
          cmd_o.load_read = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/ppsb_datapath.sv
// Datapath of the ping-pong sample buffer: fill counters, table memory,
// swap and pending flags, status light and the output register. Depends on ppsb_pkg.
module ppsb_datapath
  import ppsb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppsb_cmd_t          cmd_i,
  input  ppsb_op_e           op_i,
  input  logic [DATA_W-1:0]  data_byte_i,
  input  logic [RADDR_W-1:0] read_addr_i,
  output logic [DATA_W-1:0]  read_data_o,
  output logic               table_ready_o,
  output logic               ready_table_o,
  output logic               table_lost_o,
  output logic               full_pending_o,
  output logic               led_level_o
);

  localparam logic [ADDR_W-1:0] TableBytesA = ADDR_W'(TABLE_BYTES);

  logic [DATA_W-1:0] mem [MEM_DEPTH];

  logic [BPOS_W-1:0] bpos_q, bpos_d;
  logic [SCNT_W-1:0] scnt_q, scnt_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              fill_q, fill_d;
  logic              offered_q, offered_d;
  logic              full_q, full_d;
  logic              led_q, led_d;

  logic [DATA_W-1:0] mem_rd_q;
  logic              in_range_q;

  logic [DATA_W-1:0] rd_out_q;
  logic              ready_out_q, table_out_q, lost_out_q, full_out_q, led_out_q;

  logic              do_store, last_byte, wrap, lost;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              rd_in_range;

  always_comb begin
    do_store  = cmd_i.exec && (op_i == OP_STORE);
    last_byte = (bpos_q == BPOS_W'(BYTES_PER_SAMPLE - 1));
    wrap      = last_byte && (scnt_q == SCNT_W'(SAMPLES_PER_TABLE - 1));
    wr_addr   = (fill_q ? TableBytesA : '0) + ADDR_W'(off_q);

    rd_in_range = (ADDR_W'(read_addr_i) < TableBytesA);
    rd_addr     = rd_in_range ? ((offered_q ? TableBytesA : '0) + ADDR_W'(read_addr_i)) : '0;

    bpos_d    = bpos_q;
    scnt_d    = scnt_q;
    off_d     = off_q;
    fill_d    = fill_q;
    offered_d = offered_q;
    full_d    = full_q;
    led_d     = led_q;
    lost      = 1'b0;

    if (do_store) begin
      if (bpos_q == '0) begin
        led_d = !led_q;
      end
      bpos_d = last_byte ? '0 : bpos_q + 1'b1;
      off_d  = wrap ? '0 : off_q + 1'b1;
      if (last_byte) begin
        scnt_d = wrap ? '0 : scnt_q + 1'b1;
      end
      if (wrap) begin
        // A completed table is offered even if the earlier one was never released.
        lost      = full_q;
        offered_d = fill_q;
        fill_d    = !fill_q;
        full_d    = 1'b1;
      end
    end else if (cmd_i.exec && (op_i == OP_RELEASE)) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpos_q    <= '0;
      scnt_q    <= '0;
      off_q     <= '0;
      fill_q    <= 1'b0;
      offered_q <= 1'b0;
      full_q    <= 1'b0;
      led_q     <= 1'b0;
    end else begin
      bpos_q    <= bpos_d;
      scnt_q    <= scnt_d;
      off_q     <= off_d;
      fill_q    <= fill_d;
      offered_q <= offered_d;
      full_q    <= full_d;
      led_q     <= led_d;
    end
  end

  // Single-port table memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      mem[wr_addr] <= data_byte_i;
    end else if (cmd_i.rd_en) begin
      mem_rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      in_range_q <= rd_in_range;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      rd_out_q    <= '0;
      ready_out_q <= do_store && wrap;
      table_out_q <= offered_d;
      lost_out_q  <= lost;
      full_out_q  <= full_d;
      led_out_q   <= led_d;
    end else if (cmd_i.load_read) begin
      rd_out_q    <= in_range_q ? mem_rd_q : '0;
      ready_out_q <= 1'b0;
      table_out_q <= offered_q;
      lost_out_q  <= 1'b0;
      full_out_q  <= full_q;
      led_out_q   <= led_q;
    end
  end

  assign read_data_o    = rd_out_q;
  assign table_ready_o  = ready_out_q;
  assign ready_table_o  = table_out_q;
  assign table_lost_o   = lost_out_q;
  assign full_pending_o = full_out_q;
  assign led_level_o    = led_out_q;

endmodule

### src/ping_pong_sample_buffer_core.sv
// Ping-pong sample buffer, top level. Store, release and no-op transactions load the output
// register on acceptance; a read passes the registered read port of the table memory and
// waits there until the output register is free. A waiting result holds off the input;
// the next transaction is taken in the cycle that result is taken.
// Reset clears counters, flags and handshake state; table contents are undefined.
// Depends on ppsb_pkg, ppsb_ctrl and ppsb_datapath.
module ping_pong_sample_buffer_core
  import ppsb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // data_byte[7:0], read_addr[19:8], zero fill
  input  logic [1:0]  s_axis_tuser_i,   // opcode[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // read_data[7:0], table_ready[8], ready_table[9],
                                        // table_lost[10], full_pending[11], led_level[12]
);

  ppsb_cmd_t         cmd;
  ppsb_op_e          op;
  logic [DATA_W-1:0] read_data;
  logic              table_ready, ready_table, table_lost, full_pending, led_level;

  assign op = ppsb_op_e'(s_axis_tuser_i);

  ppsb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_op_i     (op),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  ppsb_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .op_i           (op),
    .data_byte_i    (s_axis_tdata_i[7:0]),
    .read_addr_i    (s_axis_tdata_i[19:8]),
    .read_data_o    (read_data),
    .table_ready_o  (table_ready),
    .ready_table_o  (ready_table),
    .table_lost_o   (table_lost),
    .full_pending_o (full_pending),
    .led_level_o    (led_level)
  );

  assign m_axis_tdata_o = {3'b000, led_level, full_pending, table_lost, ready_table,
                           table_ready, read_data};

  // A swap always leaves a full table pending.
  a_ready_sets_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && table_ready |-> full_pending)
    else $error("table_ready without full_pending");

  // A lost table is only reported on a swap.
  a_lost_on_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && table_lost |-> table_ready)
    else $error("table_lost without table_ready");

  // An accepted read holds off further input while the read is in flight.
  a_read_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (op == OP_READ) |=> !s_axis_tready_o)
    else $error("input accepted while a read is in flight");

endmodule
